// File: hdl/afrnl_pkg.sv
package afrnl_pkg;

  localparam int unsigned TABLE_SIZE = 4;
  localparam int unsigned IDX_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [7:0] START_DELIM    = 8'h7E;
  localparam logic [7:0] TYPE_IO_SAMPLE = 8'h92;
  localparam logic [7:0] TYPE_RECEIVE   = 8'h90;

  // Byte positions inside a frame
  localparam logic [IDX_W-1:0] IDX_START    = 17'd0;
  localparam logic [IDX_W-1:0] IDX_TYPE     = 17'd3;
  localparam logic [IDX_W-1:0] IDX_ADDR_HI  = 17'd10;
  localparam logic [IDX_W-1:0] IDX_ADDR_LO  = 17'd11;
  localparam logic [IDX_W-1:0] HDR_LEN_OFFS = 17'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

  typedef struct packed {
    logic             done;
    logic             frame_kind;
    logic [15:0]      src_addr;
    logic [15:0]      sample_first;
    logic [15:0]      sample_second;
    logic [15:0]      sample_third;
    logic [15:0]      sample_fourth;
    logic [IDX_W-1:0] end_index;
  } frame_done_t;

endpackage

// File: hdl/afrnl_frame_parser.sv
module afrnl_frame_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output afrnl_pkg::frame_done_t fd
);
  import afrnl_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0] end_r;
  logic             kind_r;
  logic [7:0]       hb0_r, hb1_r, hb2_r;
  logic [15:0]      addr_r;
  logic [7:0]       tail_r [8];

  logic             first_byte;
  logic [15:0]      addr_cur;
  logic [7:0]       tail_cur [8];
  logic             hdr_bad;
  logic [IDX_W-1:0] end_cur;
  logic             kind_cur;
  logic             inf_cur;
  logic             done;

  always_comb begin
    first_byte = (idx_r == IDX_START);
    addr_cur   = first_byte ? 16'h0000 : addr_r;
    if (idx_r == IDX_ADDR_HI) begin
      addr_cur = {rx_byte, addr_cur[7:0]};
    end
    if (idx_r == IDX_ADDR_LO) begin
      addr_cur = {addr_cur[15:8], rx_byte};
    end
    for (int i = 0; i < 8; i++) begin
      tail_cur[i] = first_byte ? 8'h00 : tail_r[i];
    end

    hdr_bad = (idx_r == IDX_TYPE) &&
              !((hb0_r == START_DELIM) &&
                ((rx_byte == TYPE_IO_SAMPLE) || (rx_byte == TYPE_RECEIVE)));
    end_cur  = (idx_r == IDX_TYPE) ? ({1'b0, hb1_r, hb2_r} + HDR_LEN_OFFS) : end_r;
    kind_cur = (idx_r == IDX_TYPE) ? (rx_byte == TYPE_RECEIVE) : kind_r;
    inf_cur  = (idx_r == IDX_TYPE) ? 1'b1 : in_frame_r;
    done     = !hdr_bad && inf_cur && (idx_r == end_cur);

    // drop a bad header or close the frame, else advance
    if (hdr_bad || done) begin
      idx_nxt      = IDX_START;
      in_frame_nxt = 1'b0;
    end else begin
      idx_nxt      = idx_r + 17'd1;
      in_frame_nxt = inf_cur;
    end

    fd.done          = done;
    fd.frame_kind    = kind_cur;
    fd.src_addr      = addr_cur;
    fd.sample_first  = {tail_cur[0], tail_cur[1]};
    fd.sample_second = {tail_cur[2], tail_cur[3]};
    fd.sample_third  = {tail_cur[4], tail_cur[5]};
    fd.sample_fourth = {tail_cur[6], tail_cur[7]};
    fd.end_index     = end_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= IDX_START;
      in_frame_r <= 1'b0;
    end else if (accept) begin
      idx_r      <= idx_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (idx_r == 17'd0) hb0_r <= rx_byte;
      if (idx_r == 17'd1) hb1_r <= rx_byte;
      if (idx_r == 17'd2) hb2_r <= rx_byte;
      addr_r <= addr_cur;
      end_r  <= end_cur;
      kind_r <= kind_cur;
      if (hdr_bad || done) begin
        for (int i = 0; i < 8; i++) begin
          tail_r[i] <= tail_cur[i];
        end
      end else begin
        for (int i = 0; i < 7; i++) begin
          tail_r[i] <= tail_cur[i+1];
        end
        tail_r[7] <= rx_byte;
      end
    end
  end

  a_frame_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (idx_r >= 17'd4) && (idx_r <= end_r))
    else $error("frame index outside header..end window");

  a_header_window: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (idx_r <= IDX_TYPE))
    else $error("index past header without a valid header");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fd.done |=> (idx_r == IDX_START) && !in_frame_r)
    else $error("parser did not restart after frame end");

endmodule

// File: hdl/afrnl_node_lookup.sv
module afrnl_node_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [afrnl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afrnl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]                      src_addr,
  output logic [2:0]                       node_id
);
  import afrnl_pkg::*;

  logic [15:0] tab_r [TABLE_SIZE];
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        tab_r[i] <= 16'h0000;
      end
      cnt_r <= 3'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ADDR_A: tab_r[0] <= cfg_wdata;
        REG_ADDR_B: tab_r[1] <= cfg_wdata;
        REG_ADDR_C: tab_r[2] <= cfg_wdata;
        REG_ADDR_D: tab_r[3] <= cfg_wdata;
        REG_COUNT:  cnt_r    <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // last matching entry wins; a count above the table size acts as full
  always_comb begin
    cnt_eff = (cnt_r > 3'(TABLE_SIZE)) ? 3'(TABLE_SIZE) : cnt_r;
    node_id = 3'd0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if ((3'(i) < cnt_eff) && (tab_r[i] == src_addr)) begin
        node_id = 3'(i + 1);
      end
    end
  end

endmodule

// File: hdl/api_frame_receiver_node_lookup.sv
// API frame receiver with node lookup.
// Input channel (in_*): one received serial byte per item in in_tdata.
// Output channel (out_*): one item per complete frame of type 0x92 or 0x90,
// carrying the frame kind, the node id looked up from the source address,
// four big-endian samples taken from the eight bytes before the end byte,
// and the end index (length + 3).
// Configuration port (cfg_*): write registers 0..3 with node addresses for
// node ids 1..4 and register 4 with the number of entries in use. Write only
// while no item is in flight.
// Throughput: one byte per cycle unless stalled. Each byte is parsed in
// the cycle it is accepted; the frame result appears on out_tvalid in the
// cycle after the end byte is accepted, set by the single output register.
// Stall: while a result waits with out_tready low, in_tready drops; when the
// result is taken, a new byte is accepted in the same cycle.
// Reset: rst_n is synchronous, active low; parser returns to byte 0 and all
// configuration registers clear to zero.
module api_frame_receiver_node_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] frame_kind, [3:1] node_id, [19:4] sample_first, [35:20] sample_second,
  // [51:36] sample_third, [67:52] sample_fourth, [84:68] frame_end_index,
  // [87:85] zero
  output logic [afrnl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [afrnl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afrnl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afrnl_pkg::*;

  logic                  accept;
  frame_done_t           fd;
  logic [2:0]            node_id;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  afrnl_frame_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_tdata),
    .fd      (fd)
  );

  afrnl_node_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src_addr  (fd.src_addr),
    .node_id   (node_id)
  );

  assign out_data_nxt = {3'b000, fd.end_index, fd.sample_fourth, fd.sample_third,
                         fd.sample_second, fd.sample_first, node_id, fd.frame_kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && fd.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fd.done) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[3:1] <= 3'(TABLE_SIZE)))
    else $error("node id beyond table size");

  a_end_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[84:68] >= HDR_LEN_OFFS) && (out_data_r[87:85] == 3'b000))
    else $error("bad end index or pad bits in result");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fd.done |=> out_valid_r)
    else $error("frame end did not load a result");

endmodule
